// ----- design/jarc_pkg.sv -----
// Package for the joint-angle repetition counter: field widths, register
// indexes, reset values, the phase type and the request structures.
// No dependencies; every other design file imports it.
package jarc_pkg;

  localparam int ANGLE_W  = 12;
  localparam int SENS_W   = 3;
  localparam int SCORE_W  = 7;
  localparam int FAULT_W  = 8;
  localparam int TARGET_W = 8;
  localparam int REPS_W   = 16;
  localparam int CODE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [SCORE_W-1:0]  FORM_LIMIT   = 7'd60;
  localparam logic [FAULT_W-1:0]  CODE_MAX     = 8'd6;
  localparam logic [SENS_W-1:0]   MIN_SENSORS  = 3'd2;

  localparam logic [ANGLE_W-1:0]  RISE_THR_RST = 12'd480;
  localparam logic [ANGLE_W-1:0]  PEAK_HYS_RST = 12'd160;
  localparam logic [TARGET_W-1:0] TARGET_RST   = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HYS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_PEAK = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  rise_threshold;
    logic [ANGLE_W-1:0]  peak_hysteresis;
    logic [TARGET_W-1:0] target_count;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] joint_angle;
    logic               session_on;
    logic [SENS_W-1:0]  sensors_present;
    logic [SCORE_W-1:0] form_score;
    logic [FAULT_W-1:0] form_fault;
  } smp_t;

  typedef struct packed {
    logic [REPS_W-1:0] reps_done;
    logic              rep_completed;
    logic              target_hit;
    logic              coach_valid;
    logic [CODE_W-1:0] coach_code;
    phase_t            phase_now;
  } res_t;

endpackage

// ----- design/jarc_if.sv -----
// Valid/ready channel interfaces for the angle samples and the results.
// Depends on jarc_pkg for the field widths.
interface jarc_in_if;
  import jarc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] joint_angle;
  logic               session_on;
  logic [SENS_W-1:0]  sensors_present;
  logic [SCORE_W-1:0] form_score;
  logic [FAULT_W-1:0] form_fault;

  modport source (output valid, joint_angle, session_on, sensors_present, form_score,
                  form_fault, input ready);
  modport sink (input valid, joint_angle, session_on, sensors_present, form_score,
                form_fault, output ready);
endinterface

interface jarc_out_if;
  import jarc_pkg::*;
  logic              valid;
  logic              ready;
  logic [REPS_W-1:0] reps_done;
  logic              rep_completed;
  logic              target_hit;
  logic              coach_valid;
  logic [CODE_W-1:0] coach_code;
  logic [1:0]        phase_now;

  modport source (output valid, reps_done, rep_completed, target_hit, coach_valid,
                  coach_code, phase_now, input ready);
  modport sink (input valid, reps_done, rep_completed, target_hit, coach_valid,
                coach_code, phase_now, output ready);
endinterface

// ----- design/joint_angle_repetition_counter.sv -----
// Top level of the joint-angle repetition counter: configuration registers,
// input register, phase tracker and result register.
// Depends on jarc_pkg, jarc_if and jarc_tracker.
//
// Usage. Angle samples arrive on the in_ch valid/ready channel, one request
// per sample, and every sample yields exactly one result request on out_ch.
// A sample first lands in an input register; the tracker then updates
// phase, last angle and repetition total and the result is captured in the
// output register. Throughput is one sample per cycle while the receiver
// does not stall, set by the combinational phase update between the two
// registers.
// When the receiver stalls, the result is held in the output register and
// the input register still takes one more sample; only when both are full
// does in_ch.ready drop. Ready flows back combinationally through the stages.
// The user writes configuration through cfg_we, cfg_idx and cfg_wdata only while
// the block is idle (not enforced); indexes beyond the three registers are ignored.
// A synchronous active-low reset empties both stages, returns the phase to
// idle, clears the last angle and total, and loads the default threshold
// (30 degrees), hysteresis (10 degrees) and target (10 repetitions).
module joint_angle_repetition_counter #(
  parameter int COUNT_BITS = jarc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jarc_in_if.sink                         in_ch,
  jarc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [jarc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [jarc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import jarc_pkg::*;

  cfg_t cfg_r;
  smp_t smp_r;
  res_t res_r;
  res_t res_nxt;
  logic smp_valid_r;
  logic out_valid_r;
  logic out_free;
  logic step_en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_threshold  <= RISE_THR_RST;
      cfg_r.peak_hysteresis <= PEAK_HYS_RST;
      cfg_r.target_count    <= TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RISE_THR: cfg_r.rise_threshold  <= cfg_wdata;
        CFG_PEAK_HYS: cfg_r.peak_hysteresis <= cfg_wdata;
        CFG_TARGET:   cfg_r.target_count    <= cfg_wdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register can take a result when it is empty or being emptied.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step_en     = smp_valid_r && out_free;
  assign in_ch.ready = !smp_valid_r || out_free;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      smp_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      smp_r.joint_angle     <= in_ch.joint_angle;
      smp_r.session_on      <= in_ch.session_on;
      smp_r.sensors_present <= in_ch.sensors_present;
      smp_r.form_score      <= in_ch.form_score;
      smp_r.form_fault      <= in_ch.form_fault;
    end
  end

  jarc_tracker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cfg     (cfg_r),
    .smp     (smp_r),
    .res     (res_nxt)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= smp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reps_done     = res_r.reps_done;
  assign out_ch.rep_completed = res_r.rep_completed;
  assign out_ch.target_hit    = res_r.target_hit;
  assign out_ch.coach_valid   = res_r.coach_valid;
  assign out_ch.coach_code    = res_r.coach_code;
  assign out_ch.phase_now     = res_r.phase_now;

endmodule

// ----- design/jarc_tracker.sv -----
// Phase tracker: holds phase, last angle and repetition total, and forms
// the result of one sample. Depends on jarc_pkg.
module jarc_tracker #(
  parameter int COUNT_BITS = jarc_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  jarc_pkg::cfg_t cfg,
  input  jarc_pkg::smp_t smp,
  output jarc_pkg::res_t res
);
  import jarc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [ANGLE_W-1:0]     last_angle_r, last_angle_nxt;
  logic [COUNT_BITS-1:0]  rep_total_r, rep_total_nxt;
  logic [ANGLE_W:0]       peak_level;
  logic                   counted;
  logic                   done;
  logic                   fault_ok;
  logic [31:0]            total_ext;

  assign peak_level = {1'b0, cfg.rise_threshold} + {1'b0, cfg.peak_hysteresis};
  assign counted    = smp.session_on && (smp.sensors_present >= MIN_SENSORS);
  assign fault_ok   = (smp.form_fault != '0) && (smp.form_fault <= CODE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      last_angle_r <= '0;
      rep_total_r  <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      last_angle_r <= last_angle_nxt;
      rep_total_r  <= rep_total_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    last_angle_nxt = last_angle_r;
    rep_total_nxt  = rep_total_r;
    done           = 1'b0;
    if (counted) begin
      last_angle_nxt = smp.joint_angle;
      unique case (phase_r)
        PH_IDLE: begin
          if (smp.joint_angle > cfg.rise_threshold) phase_nxt = PH_RISE;
        end
        PH_RISE: begin
          if ((smp.joint_angle > last_angle_r) &&
              ({1'b0, smp.joint_angle} > peak_level)) phase_nxt = PH_PEAK;
        end
        PH_PEAK: begin
          if (smp.joint_angle < last_angle_r) phase_nxt = PH_FALL;
        end
        PH_FALL: begin
          if (smp.joint_angle < cfg.rise_threshold) begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            if (rep_total_r != COUNT_MAX) rep_total_nxt = rep_total_r + 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // The result shows the low bits of the total, widened when the count is narrow.
  assign total_ext = 32'(rep_total_nxt);

  always_comb begin
    res.reps_done     = total_ext[REPS_W-1:0];
    res.rep_completed = done;
    res.target_hit    = done &&
                        (rep_total_nxt >= COUNT_BITS'(cfg.target_count));
    res.coach_valid   = done && (smp.form_score < FORM_LIMIT) && fault_ok;
    res.coach_code    = res.coach_valid ? smp.form_fault[CODE_W-1:0] : '0;
    res.phase_now     = phase_nxt;
  end

endmodule

// ----- design/jarc_checker.sv -----
// Port-level checks for the joint-angle repetition counter, and the bind
// that attaches them to the top level. Depends on jarc_pkg.
module jarc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          rep_completed,
  input logic                          target_hit,
  input logic                          coach_valid,
  input logic [jarc_pkg::CODE_W-1:0]   coach_code,
  input logic [1:0]                    phase_now
);
  import jarc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A completed repetition always returns the machine to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rep_completed |-> phase_now == PH_IDLE)
    else $error("completion without return to idle");

  // Coaching is only given on a completion, with a real code.
  a_coach_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && coach_valid |-> rep_completed && coach_code != '0)
    else $error("coaching outside a completion");

  // Outside a completion the target and coaching fields are quiet.
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rep_completed |-> !target_hit && !coach_valid && coach_code == '0)
    else $error("completion fields set without a completion");

endmodule

bind joint_angle_repetition_counter jarc_checker u_jarc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .rep_completed (out_ch.rep_completed),
  .target_hit    (out_ch.target_hit),
  .coach_valid   (out_ch.coach_valid),
  .coach_code    (out_ch.coach_code),
  .phase_now     (out_ch.phase_now)
);
